// ----- hdl/imh_pkg.sv -----
// imh_pkg: shared types, constants and the entry ordering function
// for the indexed min-heap; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;

	localparam int CAPACITY = 1024;
	localparam int ID_SPACE = 1024;
	localparam int ID_W     = 10;
	localparam int KEY_W    = 32;
	localparam int SLOT_W   = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int IDX_W    = $clog2(ID_SPACE);

	typedef enum logic [1:0] {
		REQ_PUSH   = 2'd0,
		REQ_POP    = 2'd1,
		REQ_UPDATE = 2'd2,
		REQ_QUERY  = 2'd3
	} req_code_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_ABSENT  = 3'd3,
		ST_PRESENT = 3'd4
	} status_code_t;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [ID_W-1:0]         item_id;
		logic signed [KEY_W-1:0] item_key;
	} req_t;

	typedef struct packed {
		logic [2:0]              status;
		logic [ID_W-1:0]         min_id;
		logic signed [KEY_W-1:0] min_key;
		logic                    min_valid;
		logic [SLOT_W-1:0]       entry_total;
	} rsp_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [ID_W-1:0]         id;
	} heap_entry_t;

	typedef enum logic [3:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_CHECK,
		FSM_POP_TOP,
		FSM_POP_LAST,
		FSM_UP_RD,
		FSM_UP_CMP,
		FSM_DN_RD,
		FSM_DN_A,
		FSM_DN_CMP,
		FSM_WRITE,
		FSM_FIN,
		FSM_RESP
	} fsm_t;

	// smaller key wins, smaller id breaks ties
	function automatic logic outranks(heap_entry_t a, heap_entry_t b);
		if (a.key != b.key) return a.key < b.key;
		return a.id < b.id;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/indexed_min_heap_with_key_update.sv -----
// queries and errors pass CHECK, FIN and RESP; push, pop and update also sift,
// each heap level costing UP_RD and UP_CMP going up and DN_RD, DN_A and DN_CMP
// going down (heap reads, then the compare); one request is in flight at a time
// reset: arst_n clears control; afterwards a clearing pass zeroes the
// slot-of-id memory while req_stall stays high
// indexed min-heap: top level, uses imh_pkg
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_with_key_update
	import imh_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// heap memory, slot n lives at address n-1
	heap_entry_t heap_mem [CAPACITY];
	// slot of each id, 0 means absent
	logic [SLOT_W-1:0] slot_mem [ID_SPACE];

	fsm_t state_q, state_d;

	logic              h_re, h_we;
	logic [ADDR_W-1:0] h_raddr, h_waddr;
	heap_entry_t       h_wdata, h_rdata_q;
	logic              s_re, s_we;
	logic [IDX_W-1:0]  s_raddr, s_waddr;
	logic [SLOT_W-1:0] s_wdata, s_rdata_q;

	// request and sift registers
	req_t              req_q;
	heap_entry_t       cur_q;       // entry being sifted (the hole's occupant)
	heap_entry_t       a_q;         // left child during sift-down
	heap_entry_t       popped_q;
	logic              have_b_q;
	logic              moved_q;
	logic              pop_ok_q;
	logic [SLOT_W-1:0] pos_q;
	logic [SLOT_W-1:0] count_q;
	logic [2:0]        status_q;
	logic [IDX_W-1:0]  clr_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              accept, rsp_free;
	logic [SLOT_W:0]   c2;
	logic              has_a, has_b;
	logic              up_win, dn_win, pick_b;
	heap_entry_t       best;
	logic [SLOT_W-1:0] best_slot;
	logic [SLOT_W-1:0] parent;
	logic              upd_bad;

	assign req_stall = (state_q != FSM_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// child slots of the hole
	assign c2     = {pos_q, 1'b0};
	assign has_a  = c2 <= {1'b0, count_q};
	assign has_b  = (c2 + 1'b1) <= {1'b0, count_q};
	assign parent = pos_q >> 1;

	// sift-up: moving entry against the parent just read
	assign up_win = outranks(cur_q, h_rdata_q);
	// sift-down: better child, then against the moving entry
	assign pick_b    = have_b_q && outranks(h_rdata_q, a_q);
	assign best      = pick_b ? h_rdata_q : a_q;
	assign best_slot = c2[SLOT_W-1:0] + {{(SLOT_W-1){1'b0}}, pick_b};
	assign dn_win    = outranks(best, cur_q);

	assign upd_bad = (s_rdata_q == '0) || (s_rdata_q > count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_CLEAR: if (clr_q == IDX_W'(ID_SPACE - 1)) state_d = FSM_IDLE;
			FSM_IDLE: if (accept) state_d = FSM_CHECK;
			FSM_CHECK: begin
				case (req_q.req_type)
					REQ_PUSH: begin
						if (count_q >= SLOT_W'(CAPACITY) || s_rdata_q != '0) state_d = FSM_FIN;
						else state_d = FSM_UP_RD;
					end
					REQ_POP: state_d = (count_q == '0) ? FSM_FIN : FSM_POP_TOP;
					REQ_UPDATE: state_d = upd_bad ? FSM_FIN : FSM_UP_RD;
					default: state_d = FSM_FIN;
				endcase
			end
			FSM_POP_TOP: state_d = FSM_POP_LAST;
			FSM_POP_LAST: state_d = (count_q == SLOT_W'(1)) ? FSM_FIN : FSM_DN_RD;
			FSM_UP_RD: begin
				if (pos_q == SLOT_W'(1))
					state_d = (req_q.req_type == REQ_UPDATE && !moved_q) ? FSM_DN_RD : FSM_WRITE;
				else
					state_d = FSM_UP_CMP;
			end
			FSM_UP_CMP: begin
				if (up_win) state_d = FSM_UP_RD;
				else state_d = (req_q.req_type == REQ_UPDATE && !moved_q) ? FSM_DN_RD : FSM_WRITE;
			end
			FSM_DN_RD: state_d = has_a ? FSM_DN_A : FSM_WRITE;
			FSM_DN_A: state_d = FSM_DN_CMP;
			FSM_DN_CMP: state_d = dn_win ? FSM_DN_RD : FSM_WRITE;
			FSM_WRITE: state_d = FSM_FIN;
			FSM_FIN: state_d = FSM_RESP;
			FSM_RESP: if (rsp_free) state_d = FSM_IDLE;
			default: state_d = FSM_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		h_re    = 1'b0;
		h_raddr = '0;
		h_we    = 1'b0;
		h_waddr = ADDR_W'(pos_q - 1'b1);
		h_wdata = cur_q;
		s_re    = 1'b0;
		s_raddr = req.item_id;
		s_we    = 1'b0;
		s_waddr = cur_q.id;
		s_wdata = pos_q;
		case (state_q)
			FSM_CLEAR: begin
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = '0;
			end
			FSM_IDLE: s_re = accept;
			FSM_CHECK: h_re = (req_q.req_type == REQ_POP) && (count_q != '0);
			FSM_POP_TOP: begin
				// popped id leaves the map; read the last entry
				s_we    = 1'b1;
				s_waddr = h_rdata_q.id;
				s_wdata = '0;
				h_re    = 1'b1;
				h_raddr = ADDR_W'(count_q - 1'b1);
			end
			FSM_UP_RD: begin
				h_re    = (pos_q != SLOT_W'(1));
				h_raddr = ADDR_W'(parent - 1'b1);
			end
			FSM_UP_CMP: begin
				// parent drops into the hole
				h_we    = up_win;
				h_wdata = h_rdata_q;
				s_we    = up_win;
				s_waddr = h_rdata_q.id;
				s_wdata = pos_q;
			end
			FSM_DN_RD: begin
				h_re    = has_a;
				h_raddr = ADDR_W'(c2 - 1'b1);
			end
			FSM_DN_A: begin
				h_re    = has_b;
				h_raddr = c2[ADDR_W-1:0];
			end
			FSM_DN_CMP: begin
				// better child rises into the hole
				h_we    = dn_win;
				h_wdata = best;
				s_we    = dn_win;
				s_waddr = best.id;
				s_wdata = pos_q;
			end
			FSM_WRITE: begin
				h_we = 1'b1;
				s_we = 1'b1;
			end
			FSM_FIN: h_re = (count_q != '0);
			default: ;
		endcase
	end

	// memories, read data registered and held between reads
	always_ff @(posedge clk) begin
		if (h_we) heap_mem[h_waddr] <= h_wdata;
		if (h_re) h_rdata_q <= heap_mem[h_raddr];
		if (s_we) slot_mem[s_waddr] <= s_wdata;
		if (s_re) s_rdata_q <= slot_mem[s_raddr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == FSM_CHECK && req_q.req_type == REQ_PUSH
				&& count_q < SLOT_W'(CAPACITY) && s_rdata_q == '0)
				count_q <= count_q + 1'b1;
			if (state_q == FSM_POP_LAST) count_q <= count_q - 1'b1;
			if (state_q == FSM_RESP && rsp_free) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			FSM_IDLE: begin
				if (accept) req_q <= req;
				pop_ok_q <= 1'b0;
				moved_q  <= 1'b0;
				status_q <= ST_OK;
			end
			FSM_CHECK: begin
				cur_q.key <= req_q.item_key;
				cur_q.id  <= req_q.item_id;
				case (req_q.req_type)
					REQ_PUSH: begin
						if (count_q >= SLOT_W'(CAPACITY)) status_q <= ST_FULL;
						else if (s_rdata_q != '0) status_q <= ST_PRESENT;
						pos_q <= count_q + 1'b1;
					end
					REQ_POP: if (count_q == '0) status_q <= ST_EMPTY;
					REQ_UPDATE: begin
						if (upd_bad) status_q <= ST_ABSENT;
						pos_q <= s_rdata_q;
					end
					default: ;
				endcase
			end
			FSM_POP_TOP: begin
				popped_q <= h_rdata_q;
				pop_ok_q <= 1'b1;
			end
			FSM_POP_LAST: begin
				cur_q <= h_rdata_q;
				pos_q <= SLOT_W'(1);
			end
			FSM_UP_CMP: begin
				if (up_win) begin
					pos_q   <= parent;
					moved_q <= 1'b1;
				end
			end
			FSM_DN_A: begin
				a_q      <= h_rdata_q;
				have_b_q <= has_b;
			end
			FSM_DN_CMP: if (dn_win) pos_q <= best_slot;
			FSM_RESP: begin
				if (rsp_free) begin
					rsp_q.status      <= status_q;
					rsp_q.entry_total <= count_q;
					if (pop_ok_q) begin
						rsp_q.min_id    <= popped_q.id;
						rsp_q.min_key   <= popped_q.key;
						rsp_q.min_valid <= 1'b1;
					end else if (count_q != '0) begin
						rsp_q.min_id    <= h_rdata_q.id;
						rsp_q.min_key   <= h_rdata_q.key;
						rsp_q.min_valid <= 1'b1;
					end else begin
						rsp_q.min_id    <= '0;
						rsp_q.min_key   <= '0;
						rsp_q.min_valid <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/imh_checker.sv -----
// imh_checker: port-level checks on the heap's result channel
// depends on imh_pkg; bound to indexed_min_heap_with_key_update
`timescale 1ns / 1ps
`default_nettype none
module imh_checker
	import imh_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result beat changed");

	// no entry shown means zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.min_valid |-> rsp.min_id == '0 && rsp.min_key == '0)
		else $error("min fields nonzero without an entry");

	// count never exceeds the capacity
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.entry_total <= SLOT_W'(CAPACITY))
		else $error("entry total above capacity");

	// an empty-heap error reports an empty heap
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> !rsp.min_valid && rsp.entry_total == '0)
		else $error("empty status with entries");

	// an entry shown means a nonempty heap or a pop of the last one
	a_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.min_valid && rsp.entry_total == '0 |-> rsp.status == ST_OK)
		else $error("entry shown on empty heap with error");

endmodule

bind indexed_min_heap_with_key_update imh_checker u_imh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire

// ----- tb/indexed_min_heap_with_key_update_test.sv -----
// indexed_min_heap_with_key_update_test: self-checking bench for the indexed min-heap
// drives push, pop, update and query beats, predicts each response; uses imh_pkg
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_with_key_update_test;
	import imh_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	indexed_min_heap_with_key_update i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// predicted heap image, slots from 1
	heap_entry_t heap_img [1:CAPACITY];
	int          slot_img [0:ID_SPACE-1];
	int          fill_img;

	req_t pending_beats [$];
	rsp_t expected_rsps [$];

	int mismatch_cnt;
	int idle_pct;
	int stall_pct;
	bit hold_rsp;
	bit stim_done;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// model helpers
	function automatic bit slot_wins(int a, int b);
		if (heap_img[a].key != heap_img[b].key) return heap_img[a].key < heap_img[b].key;
		return heap_img[a].id < heap_img[b].id;
	endfunction

	function automatic void slot_swap(int a, int b);
		heap_entry_t t;
		t = heap_img[a];
		heap_img[a] = heap_img[b];
		heap_img[b] = t;
		slot_img[heap_img[a].id] = a;
		slot_img[heap_img[b].id] = b;
	endfunction

	function automatic int bubble_up(int i);
		while (i > 1 && slot_wins(i, i / 2)) begin
			slot_swap(i, i / 2);
			i = i / 2;
		end
		return i;
	endfunction

	function automatic void bubble_down(int i);
		int c;
		while (2 * i <= fill_img) begin
			c = 2 * i;
			if (c + 1 <= fill_img && slot_wins(c + 1, c)) c = c + 1;
			if (!slot_wins(c, i)) break;
			slot_swap(i, c);
			i = c;
		end
	endfunction

	// applies one request to the heap image and returns the response it yields
	function automatic rsp_t heap_apply(req_t r);
		rsp_t o;
		int s;
		o = '0;
		o.status = ST_OK;
		case (req_code_t'(r.req_type))
			REQ_PUSH: begin
				if (fill_img >= CAPACITY) o.status = ST_FULL;
				else if (slot_img[r.item_id] != 0) o.status = ST_PRESENT;
				else begin
					fill_img++;
					heap_img[fill_img].key = r.item_key;
					heap_img[fill_img].id = r.item_id;
					slot_img[r.item_id] = fill_img;
					void'(bubble_up(fill_img));
				end
			end
			REQ_POP: begin
				if (fill_img == 0) o.status = ST_EMPTY;
				else begin
					o.min_valid = 1'b1;
					o.min_id = heap_img[1].id;
					o.min_key = heap_img[1].key;
					slot_img[heap_img[1].id] = 0;
					if (fill_img > 1) begin
						heap_img[1] = heap_img[fill_img];
						slot_img[heap_img[1].id] = 1;
					end
					fill_img--;
					bubble_down(1);
				end
			end
			REQ_UPDATE: begin
				s = slot_img[r.item_id];
				if (s == 0 || s > fill_img) o.status = ST_ABSENT;
				else begin
					heap_img[s].key = r.item_key;
					if (bubble_up(s) == s) bubble_down(s);
				end
			end
			default: ;
		endcase
		// everything but a good pop reports the minimum after the request
		if (!(r.req_type == REQ_POP && o.status == ST_OK) && fill_img > 0) begin
			o.min_valid = 1'b1;
			o.min_id = heap_img[1].id;
			o.min_key = heap_img[1].key;
		end
		o.entry_total = fill_img[SLOT_W-1:0];
		return o;
	endfunction

	// id pool: low ids mostly so that collisions and updates hit present entries
	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(0, 9) < 8) return ID_W'($urandom_range(0, 63));
		return ID_W'($urandom);
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 4))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return KEY_W'($signed($urandom_range(0, 15)) - 8);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_beat(req_code_t t, int id, logic signed [KEY_W-1:0] k);
		req_t r;
		r.req_type = t;
		r.item_id = ID_W'(id);
		r.item_key = k;
		pending_beats.push_back(r);
	endtask

	task automatic add_random(int n, int push_w, int pop_w, int upd_w);
		int p;
		repeat (n) begin
			p = $urandom_range(0, 99);
			if (p < push_w) add_beat(REQ_PUSH, pick_id(), pick_key());
			else if (p < push_w + pop_w) add_beat(REQ_POP, pick_id(), pick_key());
			else if (p < push_w + pop_w + upd_w) add_beat(REQ_UPDATE, pick_id(), pick_key());
			else add_beat(REQ_QUERY, pick_id(), pick_key());
		end
	endtask

	task automatic drain_all();
		while (pending_beats.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
	endtask

	// driver: beats change only at the falling edge, held while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!(req_valid && req_stall)) begin
			if (pending_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				req_valid <= 1'b1;
				req <= pending_beats[0];
			end else begin
				req_valid <= 1'b0;
				req <= {12'($urandom), $urandom};
			end
		end
		rsp_stall <= hold_rsp || ($urandom_range(0, 99) < stall_pct);
	end

	// accept point: pop the beat and run the prediction
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			expected_rsps.push_back(heap_apply(pending_beats.pop_front()));
		end
	end

	// monitor: compare each response beat with the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10) $display("unexpected response beat %p", rsp);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.status !== want.status || rsp.min_id !== want.min_id
						|| rsp.min_key !== want.min_key || rsp.min_valid !== want.min_valid
						|| rsp.entry_total !== want.entry_total) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("response mismatch: expected %p, got %p", want, rsp);
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat; covers the clearing pass
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || stim_done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int k;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_rsp = 1'b0;
		stim_done = 1'b0;
		quiet_cycles = 0;
		mismatch_cnt = 0;
		fill_img = 0;
		for (k = 0; k < ID_SPACE; k++) slot_img[k] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: empty-heap cases, key extremes, ties, id extremes, errors
		add_beat(REQ_QUERY, 0, 0);
		add_beat(REQ_POP, 0, 0);
		add_beat(REQ_UPDATE, 1023, 5);
		add_beat(REQ_PUSH, 1023, 32'sh7fff_ffff);
		add_beat(REQ_PUSH, 0, 32'sh7fff_ffff);
		add_beat(REQ_PUSH, 1023, 3);
		add_beat(REQ_PUSH, 512, 32'sh8000_0000);
		add_beat(REQ_PUSH, 341, -1);
		add_beat(REQ_QUERY, 0, 0);
		add_beat(REQ_UPDATE, 0, 32'sh8000_0000);
		add_beat(REQ_UPDATE, 512, 32'sh7fff_ffff);
		add_beat(REQ_UPDATE, 77, 0);
		add_beat(REQ_POP, 0, 0);
		add_beat(REQ_POP, 0, 0);
		add_beat(REQ_PUSH, 0, 9);
		add_beat(REQ_POP, 0, 0);
		add_beat(REQ_POP, 0, 0);
		add_beat(REQ_POP, 0, 0);
		add_beat(REQ_POP, 0, 0);
		add_beat(REQ_QUERY, 0, 0);
		drain_all();

		// random phases with different idling and stalling mixes
		add_random(100, 45, 20, 25);
		drain_all();
		idle_pct = 46;
		add_random(100, 40, 25, 25);
		drain_all();
		idle_pct = 0;
		stall_pct = 46;
		add_random(100, 35, 30, 25);
		drain_all();
		idle_pct = 19;
		stall_pct = 19;
		add_random(100, 30, 40, 20);
		drain_all();

		// long receiver hold-off while the sender keeps offering
		idle_pct = 0;
		stall_pct = 0;
		hold_rsp = 1'b1;
		add_random(40, 50, 10, 30);
		repeat (300) @(posedge clk);
		hold_rsp = 1'b0;
		drain_all();

		// grow a deep heap, repeat an id, update keys, then take half of it out by pops
		for (k = 0; k < 200; k++) add_beat(REQ_PUSH, k, pick_key());
		add_beat(REQ_PUSH, 5, 1);
		add_random(60, 0, 0, 100);
		add_random(100, 0, 100, 0);
		drain_all();

		stim_done = 1'b1;
		repeat (60) @(posedge clk);
		if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire
